[sv/bir_pkg.sv]
// ----------------------------------------------------------------------------
// bir_pkg
// Shared widths, register indices and the pipeline control word of the
// bilinear image resampler.
// ----------------------------------------------------------------------------
package bir_pkg;

    localparam int MAX_SRC_W_DEF = 256;
    localparam int MAX_SRC_H_DEF = 256;
    localparam int FRAC_BITS_DEF = 8;

    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int SRC_CFG_W  = 9;
    localparam int DST_CFG_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int LIM_W      = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_DST_W = 2'd2,
        CFG_DST_H = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               vld;
        logic               interp;
        logic               err;
        logic               wr;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
    } t_ctl;

endpackage

[sv/bir_div.sv]
// ----------------------------------------------------------------------------
// bir_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QUO_W bits, i.e. the numerator bits above QUO_W are below the divisor.
// ----------------------------------------------------------------------------
module bir_div #(
    parameter int NUM_W = 28,
    parameter int QUO_W = 16,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int REM_W = DEN_W + 1;
    localparam int HI_W  = NUM_W - QUO_W;

    logic [REM_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [REM_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_low [QUO_W];

    always_comb begin
        logic [REM_W-1:0] prev_rem;
        logic [QUO_W-1:0] prev_low;
        logic [REM_W-1:0] trial;
        logic             qbit;
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                prev_rem = {{(REM_W-HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]};
                prev_low = i_num[QUO_W-1:0];
            end else begin
                prev_rem = r_rem[k-1];
                prev_low = r_low[k-1];
            end
            trial = {prev_rem[REM_W-2:0], prev_low[QUO_W-1]};
            qbit  = (trial >= {1'b0, i_den});
            n_rem[k] = qbit ? (trial - {1'b0, i_den}) : trial;
            n_low[k] = {prev_low[QUO_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
            end
        end
    end

    assign o_quo = r_low[QUO_W-1];

endmodule

[sv/bilinear_image_resampler_top.sv]
// ----------------------------------------------------------------------------
// bilinear_image_resampler_top
// Grayscale bilinear scaler: load words fill a four-bank source store, and
// interpolate words return one output pixel each.
// ----------------------------------------------------------------------------
// One word is accepted every cycle, loads and interpolations mixed freely. An
// interpolated pixel passes these steps after its word is accepted: the
// coordinate product is registered at the accepting edge, then one quotient
// bit per stage in the two pipelined dividers, then store read, weight
// products and the weighted sum, each registered. The store is split into
// four banks by row and column parity so the four neighbours are read
// together; loads write the store at the same stage, so words act on it in
// arrival order.
// The pipeline halts only while a finished pixel waits on a stalled output.
// Source pixels must be loaded before any interpolation that uses them.
module bilinear_image_resampler_top #(
    parameter int MAX_SRC_W = bir_pkg::MAX_SRC_W_DEF,
    parameter int MAX_SRC_H = bir_pkg::MAX_SRC_H_DEF,
    parameter int FRAC_BITS = bir_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [bir_pkg::COORD_W-1:0]      i_row,
    input  logic [bir_pkg::COORD_W-1:0]      i_col,
    input  logic [bir_pkg::PIX_W-1:0]        i_pixel_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [bir_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                             o_range_error,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bir_pkg::*;

    localparam int SB_W   = $clog2(MAX_SRC_W);
    localparam int SB_H   = $clog2(MAX_SRC_H);
    localparam int SB_MAX = (SB_W > SB_H) ? SB_W : SB_H;
    localparam int QUO_W  = SB_MAX + FRAC_BITS;
    localparam int NUM_W  = COORD_W + QUO_W;
    localparam int PRD_W  = COORD_W + SB_MAX;
    localparam int FR_W   = FRAC_BITS + 1;
    localparam int WT_W   = 2 * FR_W;
    localparam int PP_W   = PIX_W + WT_W;
    localparam int SUM_W  = PP_W + 2;
    localparam int HR     = (MAX_SRC_H + 1) / 2;
    localparam int HC     = (MAX_SRC_W + 1) / 2;
    localparam int RAB    = (HR > 1) ? $clog2(HR) : 1;
    localparam int CAB    = (HC > 1) ? $clog2(HC) : 1;
    localparam int MEM_D  = 1 << (RAB + CAB);

    // ---------------- configuration ----------------
    logic [SRC_CFG_W-1:0] r_src_w, r_src_h;
    logic [DST_CFG_W-1:0] r_dst_w, r_dst_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_CFG_W'(256);
            r_src_h <= SRC_CFG_W'(256);
            r_dst_w <= DST_CFG_W'(512);
            r_dst_h <= DST_CFG_W'(512);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_W: r_src_w <= i_cfg_data[SRC_CFG_W-1:0];
                CFG_SRC_H: r_src_h <= i_cfg_data[SRC_CFG_W-1:0];
                CFG_DST_W: r_dst_w <= i_cfg_data[DST_CFG_W-1:0];
                CFG_DST_H: r_dst_h <= i_cfg_data[DST_CFG_W-1:0];
                default:   r_src_w <= r_src_w;
            endcase
        end
    end

    function automatic logic [LIM_W-1:0] clamp_src(logic [SRC_CFG_W-1:0] v,
                                                   logic [LIM_W-1:0] maxv);
        logic [LIM_W-1:0] vx;
        vx = LIM_W'(v);
        if (vx < LIM_W'(2))
            return LIM_W'(2);
        else if (vx > maxv)
            return maxv;
        else
            return vx;
    endfunction

    logic [LIM_W-1:0]     sw, sh, sw_m1, sh_m1;
    logic [SB_MAX-1:0]    smw, smh;
    logic [DST_CFG_W-1:0] dw, dh, den_w, den_h;
    logic                 div_w, div_h;

    always_comb begin
        sw    = clamp_src(r_src_w, LIM_W'(MAX_SRC_W));
        sh    = clamp_src(r_src_h, LIM_W'(MAX_SRC_H));
        sw_m1 = sw - LIM_W'(1);
        sh_m1 = sh - LIM_W'(1);
        smw   = sw_m1[SB_MAX-1:0];
        smh   = sh_m1[SB_MAX-1:0];
        dw    = (r_dst_w == '0) ? DST_CFG_W'(1) : r_dst_w;
        dh    = (r_dst_h == '0) ? DST_CFG_W'(1) : r_dst_h;
        den_w = dw - DST_CFG_W'(1);
        den_h = dh - DST_CFG_W'(1);
        div_w = (dw > DST_CFG_W'(1));
        div_h = (dh > DST_CFG_W'(1));
    end

    // ---------------- pipeline advance ----------------
    logic r_out_vld;
    logic en;

    assign en         = !(r_out_vld && i_out_stall);
    assign o_in_stall = !en;

    // ---------------- stage A: coordinate products ----------------
    t_ctl             r_a_ctl;
    logic [PRD_W-1:0] r_a_rprod, r_a_cprod;
    t_ctl             n_a_ctl;
    logic             interp_ok;

    always_comb begin
        n_a_ctl.vld    = i_in_valid;
        n_a_ctl.interp = i_mode;
        n_a_ctl.err    = i_mode && ((DST_CFG_W'(i_row) >= dh) || (DST_CFG_W'(i_col) >= dw));
        n_a_ctl.wr     = !i_mode && (LIM_W'(i_row) < sh) && (LIM_W'(i_col) < sw);
        n_a_ctl.row    = i_row;
        n_a_ctl.col    = i_col;
        n_a_ctl.pix    = i_pixel_in;
        interp_ok      = i_mode && !n_a_ctl.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (en) begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rprod <= (interp_ok && div_h) ? PRD_W'(i_row) * PRD_W'(smh) : '0;
            r_a_cprod <= (interp_ok && div_w) ? PRD_W'(i_col) * PRD_W'(smw) : '0;
        end
    end

    // ---------------- dividers ----------------
    logic [QUO_W-1:0] rquo, cquo;

    bir_div #(.NUM_W(NUM_W), .QUO_W(QUO_W), .DEN_W(DST_CFG_W)) u_div_row (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_a_rprod, {FRAC_BITS{1'b0}}}),
        .i_den (den_h),
        .o_quo (rquo)
    );

    bir_div #(.NUM_W(NUM_W), .QUO_W(QUO_W), .DEN_W(DST_CFG_W)) u_div_col (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_a_cprod, {FRAC_BITS{1'b0}}}),
        .i_den (den_w),
        .o_quo (cquo)
    );

    t_ctl r_dly [QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) r_dly[k] <= '0;
        end else if (en) begin
            r_dly[0] <= r_a_ctl;
            for (int k = 1; k < QUO_W; k++) r_dly[k] <= r_dly[k-1];
        end
    end

    // ---------------- stage B: base, fraction, store access ----------------
    t_ctl              b_ctl;
    logic [QUO_W-1:0]  fx_r, fx_c, sub_r, sub_c;
    logic [SB_MAX-1:0] ip_r, ip_c, base_h, base_w;
    logic [FR_W-1:0]   fr_u, fr_t;
    logic [RAB-1:0]    ra [4];
    logic [CAB-1:0]    ca [4];
    logic [SB_MAX:0]   rsum, csum;
    logic [1:0]        wbank;
    logic [RAB+CAB-1:0] waddr;

    always_comb begin
        b_ctl  = r_dly[QUO_W-1];
        fx_r   = div_h ? rquo : '0;
        fx_c   = div_w ? cquo : '0;
        ip_r   = fx_r[QUO_W-1:FRAC_BITS];
        ip_c   = fx_c[QUO_W-1:FRAC_BITS];
        // last source row or column: step back one, fraction becomes one
        base_h = (ip_r >= smh) ? (smh - SB_MAX'(1)) : ip_r;
        base_w = (ip_c >= smw) ? (smw - SB_MAX'(1)) : ip_c;
        sub_r  = fx_r - {base_h, {FRAC_BITS{1'b0}}};
        sub_c  = fx_c - {base_w, {FRAC_BITS{1'b0}}};
        fr_u   = sub_r[FR_W-1:0];
        fr_t   = sub_c[FR_W-1:0];
        for (int b = 0; b < 4; b++) begin
            rsum  = {1'b0, base_h} + (SB_MAX+1)'(b[1] ^ base_h[0]);
            csum  = {1'b0, base_w} + (SB_MAX+1)'(b[0] ^ base_w[0]);
            ra[b] = RAB'(rsum >> 1);
            ca[b] = CAB'(csum >> 1);
        end
        wbank = {b_ctl.row[0], b_ctl.col[0]};
        waddr = {RAB'(b_ctl.row >> 1), CAB'(b_ctl.col >> 1)};
    end

    logic [PIX_W-1:0] r_rdq [4];

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [PIX_W-1:0] r_mem [MEM_D];
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (b_ctl.vld && b_ctl.wr && (wbank == 2'(g)))
                    r_mem[waddr] <= b_ctl.pix;
                r_rdq[g] <= r_mem[{ra[g], ca[g]}];
            end
        end
    end

    logic            r_b_vld, r_b_interp, r_b_err, r_b_hp, r_b_wp;
    logic [FR_W-1:0] r_b_u, r_b_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= b_ctl.vld && b_ctl.interp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_interp <= b_ctl.interp;
            r_b_err    <= b_ctl.err;
            r_b_hp     <= base_h[0];
            r_b_wp     <= base_w[0];
            r_b_u      <= fr_u;
            r_b_t      <= fr_t;
        end
    end

    // ---------------- stage C: neighbour select and weights ----------------
    logic [FR_W-1:0]  one_fx, omu, omt;
    logic [PIX_W-1:0] nb [4];
    logic             r_c_vld, r_c_err;
    logic [PIX_W-1:0] r_c_p [4];
    logic [WT_W-1:0]  r_c_d [4];

    always_comb begin
        one_fx = FR_W'(1) << FRAC_BITS;
        omu    = one_fx - r_b_u;
        omt    = one_fx - r_b_t;
        // order: top-left, top-right, bottom-left, bottom-right
        nb[0]  = r_rdq[{r_b_hp,        r_b_wp}];
        nb[1]  = r_rdq[{r_b_hp,        !r_b_wp}];
        nb[2]  = r_rdq[{!r_b_hp,       r_b_wp}];
        nb[3]  = r_rdq[{!r_b_hp,       !r_b_wp}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld && r_b_interp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_err  <= r_b_err;
            r_c_p    <= nb;
            r_c_d[0] <= omt * omu;
            r_c_d[1] <= r_b_t * omu;
            r_c_d[2] <= omt * r_b_u;
            r_c_d[3] <= r_b_t * r_b_u;
        end
    end

    // ---------------- stage D: weighted sum and output word ----------------
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_err;

    always_comb begin
        sum = '0;
        for (int k = 0; k < 4; k++)
            sum = sum + SUM_W'(r_c_p[k]) * SUM_W'(r_c_d[k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_err <= r_c_err;
            r_out_pix <= r_c_err ? '0 : sum[2*FRAC_BITS +: PIX_W];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_pixel_out   = r_out_pix;
    assign o_range_error = r_out_err;

endmodule

[tb/sv/tb_bilinear_image_resampler_top.sv]
// ----------------------------------------------------------------------------
// tb_bilinear_image_resampler_top
// Self-checking bench for the bilinear scaler. A directed table comes first,
// then random loads and interpolations over a series of source and output
// sizes. Every output pixel is checked against a bench-side scaler, or against
// the typed expectation of its table row, and both handshakes are idled and
// stalled at random.
module tb_bilinear_image_resampler_top;
    import bir_pkg::*;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_INTERP = 1'b1;
    localparam int   SW_MAX      = 256;
    localparam int   SH_MAX      = 256;
    localparam int   FB          = 8;
    localparam int   SETTLE      = 60;
    localparam int   CYCLE_LIMIT = 600000;
    localparam int   PHASE_WORDS = 140;

    typedef struct {
        logic               mode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
        bit                 typed;
        logic [PIX_W-1:0]   t_pix;
        logic               t_err;
    } t_dir_row;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             err;
    } t_pixel_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_mode = 1'b0;
    logic [COORD_W-1:0]    i_row = '0;
    logic [COORD_W-1:0]    i_col = '0;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_range_error;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bilinear_image_resampler_top DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench copy of the scaler state
    logic [PIX_W-1:0]     img [0:SW_MAX*SH_MAX-1];
    bit                   loaded [0:SW_MAX*SH_MAX-1];
    logic [SRC_CFG_W-1:0] src_w_reg = 9'd256;
    logic [SRC_CFG_W-1:0] src_h_reg = 9'd256;
    logic [DST_CFG_W-1:0] dst_w_reg = 13'd512;
    logic [DST_CFG_W-1:0] dst_h_reg = 13'd512;

    t_pixel_res pending_pixels[$];
    int errors = 0;
    int cycles = 0;
    int idle_mode = 0;
    int hold_left = 0;
    int n_sent = 0;
    int n_load = 0, n_interp = 0, n_err = 0, n_cfg = 0;

    function automatic int eff_src(input int v, input int maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int eff_dst(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // output coordinate -> source base index and Q1.8 fraction (0..256)
    function automatic void locate_axis(input int pos, input int src, input int dst,
                                        output int base, output longint frac);
        longint fx, ip;
        fx = 0;
        if (dst > 1) fx = ((longint'(pos) * (src - 1)) << FB) / (dst - 1);
        ip = fx >> FB;
        if (ip >= src - 1) ip = src - 2;
        base = int'(ip);
        frac = fx - (ip << FB);
    endfunction

    // applies one word to the bench state; returns 1 when it yields a pixel
    function automatic bit scale_word(input logic mode, input int row, input int col,
                                      input logic [PIX_W-1:0] pin,
                                      output t_pixel_res res);
        int sw, sh, dw, dh, h, w;
        longint u, t, one, acc;
        sw = eff_src(src_w_reg, SW_MAX);
        sh = eff_src(src_h_reg, SH_MAX);
        dw = eff_dst(dst_w_reg);
        dh = eff_dst(dst_h_reg);
        one = longint'(1) << FB;
        res.pix = '0;
        res.err = 1'b0;
        if (mode == MODE_LOAD) begin
            if (row < sh && col < sw) begin
                img[row*SW_MAX + col] = pin;
                loaded[row*SW_MAX + col] = 1'b1;
            end
            return 1'b0;
        end
        if (row >= dh || col >= dw) begin
            res.err = 1'b1;
            return 1'b1;
        end
        locate_axis(row, sh, dh, h, u);
        locate_axis(col, sw, dw, w, t);
        acc = img[h*SW_MAX + w] * (one - t) * (one - u)
            + img[h*SW_MAX + w + 1] * t * (one - u)
            + img[(h+1)*SW_MAX + w + 1] * t * u
            + img[(h+1)*SW_MAX + w] * (one - t) * u;
        res.pix = PIX_W'(acc >> (2*FB));
        return 1'b1;
    endfunction

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    task automatic send_word(input logic mode, input int row, input int col,
                             input logic [PIX_W-1:0] pin, input bit typed = 0,
                             input logic [PIX_W-1:0] t_pix = '0, input logic t_err = 0);
        t_pixel_res res;
        while ((idle_mode == 1 && $urandom_range(99) < 78) ||
               (idle_mode == 3 && $urandom_range(99) < 25)) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_row <= COORD_W'(row);
        i_col <= COORD_W'(col);
        i_pixel_in <= pin;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (scale_word(mode, row, col, pin, res)) begin
            if (typed) begin
                res.pix = t_pix;
                res.err = t_err;
            end
            pending_pixels.push_back(res);
            if (res.err) n_err++; else n_interp++;
        end else if (mode == MODE_LOAD) begin
            n_load++;
        end
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SRC_W: src_w_reg = data[SRC_CFG_W-1:0];
            CFG_SRC_H: src_h_reg = data[SRC_CFG_W-1:0];
            CFG_DST_W: dst_w_reg = data;
            CFG_DST_H: dst_h_reg = data;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // loads those of the four neighbours an in-range interpolation would read that are not yet loaded
    task automatic load_neighbours(input int row, input int col);
        int h, w, a;
        longint f;
        locate_axis(row, eff_src(src_h_reg, SH_MAX), eff_dst(dst_h_reg), h, f);
        locate_axis(col, eff_src(src_w_reg, SW_MAX), eff_dst(dst_w_reg), w, f);
        for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++) begin
                a = (h+dr)*SW_MAX + w + dc;
                if (!loaded[a]) send_word(MODE_LOAD, h+dr, w+dc, PIX_W'($urandom_range(255)));
            end
    endtask

    // count takes in every word sent, neighbour loads included
    task automatic random_words(input int count);
        int start, dw, dh, r, c, roll;
        start = n_sent;
        dw = eff_dst(dst_w_reg);
        dh = eff_dst(dst_h_reg);
        while (n_sent - start < count) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                // noise loads, often outside the source and so dropped
                send_word(MODE_LOAD, $urandom_range(4095) >> $urandom_range(11),
                          $urandom_range(4095) >> $urandom_range(11),
                          PIX_W'($urandom_range(255)));
            end else if (roll < 25 && (dh <= 4095 || dw <= 4095)) begin
                if (dh <= 4095 && (dw > 4095 || $urandom_range(1))) begin
                    r = $urandom_range(4095, dh);
                    c = $urandom_range(4095);
                end else begin
                    r = $urandom_range(4095);
                    c = $urandom_range(4095, dw);
                end
                send_word(MODE_INTERP, r, c, PIX_W'($urandom_range(255)));
            end else begin
                r = $urandom_range((dh > 4096 ? 4096 : dh) - 1);
                c = $urandom_range((dw > 4096 ? 4096 : dw) - 1);
                load_neighbours(r, c);
                send_word(MODE_INTERP, r, c, PIX_W'($urandom_range(255)));
            end
        end
    endtask

    // receiver side: random stall, or a long hold when one is asked for
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (idle_mode == 2 && $urandom_range(99) < 78) ||
                           (idle_mode == 3 && $urandom_range(99) < 25);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                report("unexpected pixel", o_pixel_out, -1);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_out !== want.pix) report("pixel_out", o_pixel_out, want.pix);
                if (o_range_error !== want.err) report("range_error", o_range_error, want.err);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("bilinear_image_resampler_top regression: fail");
            $finish;
        end
    end

    t_dir_row dir_rows[] = '{
        '{MODE_LOAD,   0,    0,    8'h00, 0, 8'h00, 0},
        '{MODE_LOAD,   0,    1,    8'hFF, 0, 8'h00, 0},
        '{MODE_LOAD,   1,    0,    8'h80, 0, 8'h00, 0},
        '{MODE_LOAD,   1,    1,    8'h7F, 0, 8'h00, 0},
        '{MODE_INTERP, 0,    0,    8'h00, 1, 8'h00, 0},
        '{MODE_INTERP, 0,    1,    8'h00, 0, 8'h00, 0},
        '{MODE_INTERP, 1,    0,    8'hFF, 0, 8'h00, 0},
        '{MODE_INTERP, 1,    1,    8'h00, 0, 8'h00, 0},
        '{MODE_LOAD,   254,  254,  8'h10, 0, 8'h00, 0},
        '{MODE_LOAD,   254,  255,  8'h20, 0, 8'h00, 0},
        '{MODE_LOAD,   255,  254,  8'h30, 0, 8'h00, 0},
        '{MODE_LOAD,   255,  255,  8'hAB, 0, 8'h00, 0},
        '{MODE_INTERP, 511,  511,  8'h00, 1, 8'hAB, 0},
        '{MODE_INTERP, 510,  510,  8'h00, 0, 8'h00, 0},
        '{MODE_INTERP, 512,  0,    8'h00, 1, 8'h00, 1},
        '{MODE_INTERP, 0,    512,  8'h00, 1, 8'h00, 1},
        '{MODE_INTERP, 4095, 4095, 8'hFF, 1, 8'h00, 1},
        '{MODE_LOAD,   4095, 4095, 8'hFF, 0, 8'h00, 0},
        '{MODE_LOAD,   256,  0,    8'h55, 0, 8'h00, 0},
        '{MODE_INTERP, 0,    0,    8'h00, 1, 8'h00, 0}
    };

    // src_w, src_h, dst_w, dst_h per phase, extremes and out-of-range codes
    int phase_cfg[8][4] = '{
        '{2,   2,   1,    1},
        '{256, 256, 4096, 4096},
        '{0,   511, 0,    8191},
        '{5,   3,   7,    9},
        '{1,   300, 13,   2},
        '{16,  16,  40,   33},
        '{-1,  -1,  -1,   -1},
        '{256, 2,   3,    4095}
    };

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_word(dir_rows[k].mode, dir_rows[k].row, dir_rows[k].col, dir_rows[k].pix,
                      dir_rows[k].typed, dir_rows[k].t_pix, dir_rows[k].t_err);
        quiesce();

        for (int p = 0; p < 8; p++) begin
            cfg_write(CFG_SRC_W, CFG_DATA_W'(phase_cfg[p][0] < 0 ?
                                             $urandom_range(8191) : phase_cfg[p][0]));
            cfg_write(CFG_SRC_H, CFG_DATA_W'(phase_cfg[p][1] < 0 ?
                                             $urandom_range(8191) : phase_cfg[p][1]));
            cfg_write(CFG_DST_W, CFG_DATA_W'(phase_cfg[p][2] < 0 ?
                                             $urandom_range(8191) : phase_cfg[p][2]));
            cfg_write(CFG_DST_H, CFG_DATA_W'(phase_cfg[p][3] < 0 ?
                                             $urandom_range(8191) : phase_cfg[p][3]));
            idle_mode = p % 4;
            // long output hold while words keep coming, to back the pipe up
            if (p == 4) hold_left = 400;
            random_words(PHASE_WORDS);
            quiesce();
        end

        $display("covered %0d loads, %0d pixels, %0d range errors, %0d register writes",
                 n_load, n_interp, n_err, n_cfg);
        $display("idle patterns: none, sender, receiver, both; one long output hold");
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("bilinear_image_resampler_top regression: pass");
        end else begin
            $display("bilinear_image_resampler_top regression: fail");
        end
        $finish;
    end

endmodule
